>>> hw/rtl/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types and constants of the text console glyph renderer: font
// geometry, command and register codes, control characters.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  // Font geometry
  localparam int unsigned GLYPH_WIDTH = 8;
  localparam int unsigned GLYPH_ROWS  = 16;
  localparam int unsigned GLYPH_COUNT = 256;
  localparam int unsigned ROW_W       = $clog2(GLYPH_ROWS);
  localparam int unsigned CODE_W      = $clog2(GLYPH_COUNT);
  localparam int unsigned ADDR_W      = CODE_W + ROW_W;
  localparam int unsigned FONT_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;

  // Field widths
  localparam int unsigned CUR_W      = 13;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned SCR_W      = 13;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned BITS_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CUR_W-1:0] CURSOR_MAX = {CUR_W{1'b1}};

  // Register reset values
  localparam logic [SCR_W-1:0]   RST_SCREEN_WIDTH  = SCR_W'(1024);
  localparam logic [SCR_W-1:0]   RST_SCREEN_HEIGHT = SCR_W'(768);
  localparam logic [COLOR_W-1:0] RST_FG_COLOR      = 32'h0000_FF00;
  localparam logic [COLOR_W-1:0] RST_BG_COLOR      = 32'h0000_0000;

  // Control characters
  localparam logic [CODE_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CODE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CODE_W-1:0] CH_RETURN  = 8'h0D;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_CURSOR = 2'd1,
    CMD_CHAR   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_FG     = 2'd2,
    CFG_BG     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRAP,
    ST_ROWS
  } seq_state_e;

  // Font memory access from the sequencer
  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [BITS_W-1:0] wdata;
  } ram_req_t;

endpackage

>>> hw/rtl/tcgr_font_ram.sv
// ----------------------------------------------------------------------------
// tcgr_font_ram
// Single-port font store, one glyph row per entry, registered read data
// that holds while the port is not enabled.
// ----------------------------------------------------------------------------
module tcgr_font_ram (
  input  logic                    clk_i,
  input  tcgr_pkg::ram_req_t      req_i,
  output logic [tcgr_pkg::BITS_W-1:0] rdata_o
);
  import tcgr_pkg::*;

  logic [BITS_W-1:0] mem [FONT_DEPTH];
  logic [BITS_W-1:0] rdata_q;

  // Write or read one entry per enabled cycle
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_q <= mem[req_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/tcgr_seq.sv
// ----------------------------------------------------------------------------
// tcgr_seq
// Command sequencer: cursor state, line and top wrap, glyph row walk over
// the font store and the output register for row beats.
// ----------------------------------------------------------------------------
module tcgr_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     cmd_i,
  input  logic [tcgr_pkg::CODE_W-1:0]    char_code_i,
  input  logic [tcgr_pkg::ROW_W-1:0]     row_index_i,
  input  logic [tcgr_pkg::BITS_W-1:0]    glyph_row_i,
  input  logic [tcgr_pkg::COORD_W-1:0]   pos_x_i,
  input  logic [tcgr_pkg::COORD_W-1:0]   pos_y_i,
  input  logic [tcgr_pkg::SCR_W-1:0]     screen_width_i,
  input  logic [tcgr_pkg::SCR_W-1:0]     screen_height_i,
  output tcgr_pkg::ram_req_t             ram_req_o,
  input  logic [tcgr_pkg::BITS_W-1:0]    ram_rdata_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tcgr_pkg::COORD_W-1:0]   pixel_x_o,
  output logic [tcgr_pkg::COORD_W-1:0]   pixel_y_o,
  output logic [tcgr_pkg::BITS_W-1:0]    row_bits_o,
  output logic                           last_row_o
);
  import tcgr_pkg::*;

  seq_state_e        state_q, state_d;
  logic [CUR_W-1:0]  cur_x_q, cur_x_d;
  logic [CUR_W-1:0]  cur_y_q, cur_y_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic [ROW_W-1:0]  row_q, row_d;

  // Row read in flight: its data sits in the font store's read register
  logic               pend_q, pend_d;
  logic [COORD_W-1:0] pend_x_q, pend_x_d;
  logic [COORD_W-1:0] pend_y_q, pend_y_d;
  logic               pend_last_q, pend_last_d;

  logic               out_valid_q, out_valid_d;
  logic [COORD_W-1:0] out_x_q, out_x_d;
  logic [COORD_W-1:0] out_y_q, out_y_d;
  logic [BITS_W-1:0]  out_bits_q, out_bits_d;
  logic               out_last_q, out_last_d;

  cmd_e        cmd;
  logic        accept;
  logic        is_draw;
  logic        load_out;
  logic        issue;
  logic        last_issue;
  logic [CUR_W:0] x_end;
  logic [CUR_W:0] y_down;
  logic [CUR_W:0] y_end;
  logic [CUR_W-1:0] y_step;
  logic [CUR_W-1:0] wrap_x;
  logic [CUR_W-1:0] wrap_y;

  assign cmd     = cmd_e'(cmd_i);
  assign accept  = in_valid_i && in_ready_o;
  assign is_draw = (cmd == CMD_CHAR) && (char_code_i != CH_NUL)
                && (char_code_i != CH_NEWLINE) && (char_code_i != CH_RETURN);

  // Move down one text line, saturating at the cursor maximum
  assign y_down = {1'b0, cur_y_q} + (CUR_W+1)'(GLYPH_ROWS);
  assign y_step = (y_down > {1'b0, CURSOR_MAX}) ? CURSOR_MAX : y_down[CUR_W-1:0];

  // Line wrap, then wrap to top
  assign x_end = {1'b0, cur_x_q} + (CUR_W+1)'(GLYPH_WIDTH);
  always_comb begin
    if (x_end > {1'b0, screen_width_i}) begin
      wrap_x = '0;
      wrap_y = y_step;
    end else begin
      wrap_x = cur_x_q;
      wrap_y = cur_y_q;
    end
    y_end = {1'b0, wrap_y} + (CUR_W+1)'(GLYPH_ROWS);
    if (y_end > {1'b0, screen_height_i}) begin
      wrap_y = '0;
    end
  end

  // Output slot frees when empty or when its beat is taken
  assign load_out   = pend_q && (!out_valid_q || out_ready_i);
  assign last_issue = issue && (row_q == ROW_W'(GLYPH_ROWS - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_draw) begin
          state_d = ST_WRAP;
        end
      end
      ST_WRAP: state_d = ST_ROWS;
      ST_ROWS: begin
        if (last_issue) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs: handshake and font store port
  always_comb begin
    in_ready_o      = 1'b0;
    issue           = 1'b0;
    ram_req_o.en    = 1'b0;
    ram_req_o.we    = 1'b0;
    ram_req_o.addr  = {code_q, row_q};
    ram_req_o.wdata = glyph_row_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (cmd == CMD_LOAD)) begin
          ram_req_o.en   = 1'b1;
          ram_req_o.we   = 1'b1;
          ram_req_o.addr = {char_code_i, row_index_i};
        end
      end
      ST_WRAP: ;
      ST_ROWS: begin
        issue        = !pend_q || load_out;
        ram_req_o.en = issue;
      end
      default: ;
    endcase
  end

  // Cursor, glyph code and row counter
  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    code_d  = code_q;
    row_d   = row_q;
    if (accept) begin
      priority if (cmd == CMD_CURSOR) begin
        cur_x_d = CUR_W'(pos_x_i);
        cur_y_d = CUR_W'(pos_y_i);
      end else if ((cmd == CMD_CHAR) && (char_code_i == CH_NEWLINE)) begin
        cur_y_d = y_step;
      end else if ((cmd == CMD_CHAR) && (char_code_i == CH_RETURN)) begin
        cur_x_d = '0;
      end else if (is_draw) begin
        code_d = char_code_i;
        row_d  = '0;
      end else begin
        cur_x_d = cur_x_q;
      end
    end
    if (state_q == ST_WRAP) begin
      cur_x_d = wrap_x;
      cur_y_d = wrap_y;
    end
    if (issue) begin
      row_d = row_q + ROW_W'(1);
    end
    if (last_issue) begin
      cur_x_d = cur_x_q + CUR_W'(GLYPH_WIDTH);
    end
  end

  // Track the row read in flight
  always_comb begin
    pend_d      = pend_q;
    pend_x_d    = pend_x_q;
    pend_y_d    = pend_y_q;
    pend_last_d = pend_last_q;
    if (load_out) begin
      pend_d = 1'b0;
    end
    if (issue) begin
      pend_d      = 1'b1;
      pend_x_d    = cur_x_q[COORD_W-1:0];
      pend_y_d    = cur_y_q[COORD_W-1:0] + COORD_W'(row_q);
      pend_last_d = (row_q == ROW_W'(GLYPH_ROWS - 1));
    end
  end

  // Output register: load a row beat, drop it when taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_bits_d  = out_bits_q;
    out_last_d  = out_last_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      out_x_d     = pend_x_q;
      out_y_d     = pend_y_q;
      out_bits_d  = ram_rdata_i;
      out_last_d  = pend_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q      <= code_d;
    row_q       <= row_d;
    pend_x_q    <= pend_x_d;
    pend_y_q    <= pend_y_d;
    pend_last_q <= pend_last_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_bits_q  <= out_bits_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = out_x_q;
  assign pixel_y_o   = out_y_q;
  assign row_bits_o  = out_bits_q;
  assign last_row_o  = out_last_q;

endmodule

>>> hw/rtl/text_console_glyph_renderer_top.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_top
// Text console renderer with a stored 8x16 bitmap font.
//
// Input channel (in_valid_i/in_ready_o) takes one command beat: load a font
// row, set the cursor, or a character. Loads, cursor moves, newline, carriage
// return and zero bytes give no output. A drawn character first passes a
// wrap state for line and top wrap, then walks the 16 glyph rows through
// the single-port font store, one row read a cycle while the output does
// not stall; input is not ready during the walk. The first row beat passes
// the font store's read register and then the output register to reach the
// output channel (out_valid_o/out_ready_i), the rows follow one a cycle
// while the receiver does not stall, and last_row_o marks the final one.
// The output register holds a beat while the receiver stalls; the row walk
// pauses with it, and the next command is taken in the cycle after the last
// row read is issued.
// Reset clears the cursor to the top left and loads the register defaults
// (1024x768, green on black). The font store is not cleared; load every
// glyph before drawing it. The user writes the registers through cfg_we_i,
// cfg_idx_i and cfg_wdata_i only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         cmd_i,
  input  logic [tcgr_pkg::CODE_W-1:0]        char_code_i,
  input  logic [tcgr_pkg::ROW_W-1:0]         row_index_i,
  input  logic [tcgr_pkg::BITS_W-1:0]        glyph_row_i,
  input  logic [tcgr_pkg::COORD_W-1:0]       pos_x_i,
  input  logic [tcgr_pkg::COORD_W-1:0]       pos_y_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [tcgr_pkg::COORD_W-1:0]       pixel_x_o,
  output logic [tcgr_pkg::COORD_W-1:0]       pixel_y_o,
  output logic [tcgr_pkg::BITS_W-1:0]        row_bits_o,
  output logic [tcgr_pkg::COLOR_W-1:0]       fore_color_o,
  output logic [tcgr_pkg::COLOR_W-1:0]       back_color_o,
  output logic                               last_row_o
);
  import tcgr_pkg::*;

  logic [SCR_W-1:0]   screen_width_q;
  logic [SCR_W-1:0]   screen_height_q;
  logic [COLOR_W-1:0] fg_color_q;
  logic [COLOR_W-1:0] bg_color_q;
  ram_req_t           ram_req;
  logic [BITS_W-1:0]  ram_rdata;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= RST_SCREEN_WIDTH;
      screen_height_q <= RST_SCREEN_HEIGHT;
      fg_color_q      <= RST_FG_COLOR;
      bg_color_q      <= RST_BG_COLOR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  screen_width_q  <= cfg_wdata_i[SCR_W-1:0];
        CFG_HEIGHT: screen_height_q <= cfg_wdata_i[SCR_W-1:0];
        CFG_FG:     fg_color_q      <= cfg_wdata_i[COLOR_W-1:0];
        CFG_BG:     bg_color_q      <= cfg_wdata_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  tcgr_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .char_code_i     (char_code_i),
    .row_index_i     (row_index_i),
    .glyph_row_i     (glyph_row_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .ram_req_o       (ram_req),
    .ram_rdata_i     (ram_rdata),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .row_bits_o      (row_bits_o),
    .last_row_o      (last_row_o)
  );

  tcgr_font_ram u_font_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // The user keeps the colors fixed while beats are pending; not enforced.
  assign fore_color_o = fg_color_q;
  assign back_color_o = bg_color_q;

endmodule
